>>> rtl/core/lrnk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Light registry nearest-K package
// Shared types, request and status codes and sizing constants.
// ----------------------------------------------------------------------------
package lrnk_pkg;

   localparam int REGISTRY_DEPTH_DEF  = 32;
   localparam int BEST_LIST_DEPTH_DEF = 8;
   localparam int RESULT_CAP          = 8;
   localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

   typedef enum logic [1:0] {
      REQ_REGISTER = 2'd0,
      REQ_CLEAR    = 2'd1,
      REQ_QUERY    = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_NONE  = 2'd2,
      ST_SPARE = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        light_radius;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  light_index;
      logic [31:0] score;
      logic [3:0]  found_count;
      logic        last_result;
   } rsp_type_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_REGISTER,
      CMD_CLEAR,
      CMD_LOAD_QUERY,
      CMD_READ_LIGHT,
      CMD_DIFF,
      CMD_SQUARE,
      CMD_SUM,
      CMD_DIV_START,
      CMD_DIV_STEP,
      CMD_INSERT,
      CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
   } dp_ctrl_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic emit_done;
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/core/lrnk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Light registry controller
// Sequences register, clear and query requests over the datapath.
// ----------------------------------------------------------------------------
module lrnk_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             req_code,
   input  wire lrnk_pkg::dp_status_type stat,
   output logic                        busy,
   output lrnk_pkg::dp_ctrl_type       ctrl
);
   import lrnk_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_REG, S_READ, S_DIFF, S_SQ, S_SUM, S_DSTART, S_DIV, S_INS, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl.cmd = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_code)
                  REQ_REGISTER: begin
                     ctrl.cmd = CMD_REGISTER;
                     state_in = S_REG;
                  end
                  REQ_CLEAR: ctrl.cmd = CMD_CLEAR;
                  REQ_QUERY: begin
                     ctrl.cmd = CMD_LOAD_QUERY;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_REG: state_in = S_IDLE;
         S_READ: begin
            if (stat.scan_done) begin
               state_in = S_EMIT;
            end else begin
               ctrl.cmd = CMD_READ_LIGHT;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            ctrl.cmd = CMD_DIFF;
            state_in = S_SQ;
         end
         S_SQ: begin
            ctrl.cmd = CMD_SQUARE;
            state_in = S_SUM;
         end
         S_SUM: begin
            ctrl.cmd = CMD_SUM;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            ctrl.cmd = CMD_DIV_START;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctrl.cmd = CMD_DIV_STEP;
            if (stat.div_done) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            ctrl.cmd = CMD_INSERT;
            state_in = S_READ;
         end
         S_EMIT: begin
            ctrl.cmd = CMD_EMIT;
            if (stat.emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/lrnk_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Light registry datapath
// Light store, score pipeline, restoring divider, best list and result output.
// ----------------------------------------------------------------------------
module lrnk_dp #(
   parameter int REGISTRY_DEPTH  = lrnk_pkg::REGISTRY_DEPTH_DEF,
   parameter int BEST_LIST_DEPTH = lrnk_pkg::BEST_LIST_DEPTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lrnk_pkg::req_type_type  req,
   input  wire logic                    csr_wr_en,
   input  wire logic [3:0]              csr_wr_data,
   input  wire lrnk_pkg::dp_ctrl_type   ctrl,
   output lrnk_pkg::dp_status_type      stat,
   output logic                         rsp_valid,
   output lrnk_pkg::rsp_type_type       rsp
);
   import lrnk_pkg::*;

   localparam int AW = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
   localparam int TW = $clog2(REGISTRY_DEPTH + 1);
   localparam int BW = (BEST_LIST_DEPTH > 1) ? $clog2(BEST_LIST_DEPTH) : 1;
   localparam int CW = $clog2(BEST_LIST_DEPTH + 1);
   localparam int CAPV = (BEST_LIST_DEPTH < RESULT_CAP) ? BEST_LIST_DEPTH : RESULT_CAP;

   logic [31:0] mem_x [REGISTRY_DEPTH];
   logic [31:0] mem_y [REGISTRY_DEPTH];
   logic [31:0] mem_z [REGISTRY_DEPTH];
   logic [31:0] mem_r [REGISTRY_DEPTH];

   logic [TW-1:0] total_ff;
   logic [3:0]    wanted_ff;
   logic [CW-1:0] cap_ff, n_ff, emit_ff;
   logic [TW-1:0] scan_ff;
   logic [31:0]   qx_ff, qy_ff, qz_ff;
   logic [31:0]   lx_ff, ly_ff, lz_ff, lr_ff;
   logic [31:0]   dx_ff, dy_ff, dz_ff;
   logic [63:0]   sx_ff, sy_ff, sz_ff;
   logic [65:0]   sum_ff;
   logic [63:0]   div_ff;
   logic [81:0]   num_ff;
   logic [65:0]   rem_ff;
   logic [81:0]   quo_ff;
   logic [6:0]    step_ff;
   logic [31:0]   bs_ff [BEST_LIST_DEPTH];
   logic [4:0]    bi_ff [BEST_LIST_DEPTH];

   logic          full;
   logic [31:0]   score;
   logic [65:0]   rem_sh;
   logic [BEST_LIST_DEPTH-1:0] less;
   logic [CW-1:0] at;
   logic [AW-1:0] waddr, raddr;
   logic [TW-1:0] scan_next;
   logic [CW-1:0] cap_cfg;

   assign full = (total_ff >= TW'(REGISTRY_DEPTH));
   assign waddr = total_ff[AW-1:0];
   assign raddr = scan_ff[AW-1:0];
   assign scan_next = scan_ff + TW'(1);
   assign cap_cfg = (wanted_ff > 4'(CAPV)) ? CW'(CAPV) : CW'(wanted_ff);
   assign rem_sh = {rem_ff[64:0], num_ff[81]};
   assign score = (|quo_ff[81:32]) ? 32'hFFFF_FFFF : quo_ff[31:0];

   always_comb begin
      at = n_ff;
      for (int j = BEST_LIST_DEPTH - 1; j >= 0; j--) begin
         less[j] = (CW'(j) < n_ff) && (score < bs_ff[j]);
         if (less[j]) begin
            at = CW'(j);
         end
      end
   end

   assign stat.scan_done = (scan_ff >= total_ff) || (cap_ff == '0);
   assign stat.div_done = (step_ff == 7'd0);
   assign stat.emit_done = (n_ff == '0) || (emit_ff + CW'(1) >= n_ff);

   always_ff @(posedge clock) begin
      if (ctrl.cmd == CMD_REGISTER && !full) begin
         mem_x[waddr] <= req.pos_x;
         mem_y[waddr] <= req.pos_y;
         mem_z[waddr] <= req.pos_z;
         mem_r[waddr] <= req.light_radius;
      end
      if (ctrl.cmd == CMD_READ_LIGHT) begin
         lx_ff <= mem_x[raddr];
         ly_ff <= mem_y[raddr];
         lz_ff <= mem_z[raddr];
         lr_ff <= mem_r[raddr];
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.cmd)
         CMD_LOAD_QUERY: begin
            qx_ff <= req.pos_x;
            qy_ff <= req.pos_y;
            qz_ff <= req.pos_z;
         end
         CMD_DIFF: begin
            dx_ff <= ($signed(lx_ff) >= $signed(qx_ff)) ? lx_ff - qx_ff : qx_ff - lx_ff;
            dy_ff <= ($signed(ly_ff) >= $signed(qy_ff)) ? ly_ff - qy_ff : qy_ff - ly_ff;
            dz_ff <= ($signed(lz_ff) >= $signed(qz_ff)) ? lz_ff - qz_ff : qz_ff - lz_ff;
            div_ff <= (lr_ff < ONE_Q16) ? 64'(ONE_Q16) : 64'(lr_ff);
         end
         CMD_SQUARE: begin
            sx_ff <= 64'(dx_ff) * 64'(dx_ff);
            sy_ff <= 64'(dy_ff) * 64'(dy_ff);
            sz_ff <= 64'(dz_ff) * 64'(dz_ff);
            div_ff <= div_ff[31:0] * div_ff[31:0];
         end
         CMD_SUM: sum_ff <= 66'(sx_ff) + 66'(sy_ff) + 66'(sz_ff);
         CMD_DIV_START: begin
            num_ff <= {sum_ff, 16'h0000};
            rem_ff <= '0;
            quo_ff <= '0;
            step_ff <= 7'd82;
         end
         CMD_DIV_STEP: begin
            if (step_ff != 7'd0) begin
               num_ff <= {num_ff[80:0], 1'b0};
               step_ff <= step_ff - 7'd1;
               if (rem_sh >= 66'(div_ff)) begin
                  rem_ff <= rem_sh - 66'(div_ff);
                  quo_ff <= {quo_ff[80:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[80:0], 1'b0};
               end
            end
         end
         CMD_INSERT: begin
            if (at < cap_ff) begin
               for (int j = 0; j < BEST_LIST_DEPTH; j++) begin
                  if (CW'(j) == at) begin
                     bs_ff[j] <= score;
                     bi_ff[j] <= 5'(scan_ff);
                  end else if (CW'(j) > at && j > 0) begin
                     bs_ff[j] <= bs_ff[(j > 0) ? j - 1 : 0];
                     bi_ff[j] <= bi_ff[(j > 0) ? j - 1 : 0];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         wanted_ff <= 4'd8;
         rsp_valid <= 1'b0;
         scan_ff <= '0;
         n_ff <= '0;
         emit_ff <= '0;
         cap_ff <= '0;
      end else begin
         rsp_valid <= (ctrl.cmd == CMD_REGISTER) || (ctrl.cmd == CMD_EMIT);
         if (csr_wr_en) begin
            wanted_ff <= csr_wr_data;
         end
         case (ctrl.cmd)
            CMD_REGISTER: begin
               rsp.status <= full ? ST_FULL : ST_OK;
               rsp.light_index <= full ? 5'd0 : 5'(total_ff);
               rsp.score <= '0;
               rsp.found_count <= '0;
               rsp.last_result <= 1'b1;
               if (!full) begin
                  total_ff <= total_ff + TW'(1);
               end
            end
            CMD_CLEAR: total_ff <= '0;
            CMD_LOAD_QUERY: begin
               scan_ff <= '0;
               n_ff <= '0;
               emit_ff <= '0;
               cap_ff <= cap_cfg;
            end
            CMD_INSERT: begin
               scan_ff <= scan_next;
               if (at < cap_ff && n_ff < cap_ff) begin
                  n_ff <= n_ff + CW'(1);
               end
            end
            CMD_EMIT: begin
               emit_ff <= emit_ff + CW'(1);
               if (n_ff == '0) begin
                  rsp.status <= ST_NONE;
                  rsp.light_index <= '0;
                  rsp.score <= '0;
                  rsp.found_count <= '0;
                  rsp.last_result <= 1'b1;
               end else begin
                  rsp.status <= ST_OK;
                  rsp.light_index <= bi_ff[emit_ff[BW-1:0]];
                  rsp.score <= bs_ff[emit_ff[BW-1:0]];
                  rsp.found_count <= 4'(n_ff);
                  rsp.last_result <= (emit_ff + CW'(1) >= n_ff);
               end
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/light_registry_nearest_k_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Light registry nearest-K top level
// Register: busy for one cycle; its result beat is in the cycle after start.
// Clear and unknown requests never raise busy and return nothing.
// A query runs each stored light through read, diff, square, sum, the 82-step
// divider and insert, then ends the scan and emits beats that cannot stall.
// Synchronous reset empties the registry and sets wanted_ff to 8.
// ----------------------------------------------------------------------------
module light_registry_nearest_k_top #(
   parameter int REGISTRY_DEPTH  = lrnk_pkg::REGISTRY_DEPTH_DEF,
   parameter int BEST_LIST_DEPTH = lrnk_pkg::BEST_LIST_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire lrnk_pkg::req_type_type req_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [3:0]             csr_wr_data,
   output logic                        rsp_strobe,
   output lrnk_pkg::rsp_type_type      rsp_data
);
   import lrnk_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type stat;

   lrnk_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_code(req_data.req_type),
      .stat(stat), .busy(busy), .ctrl(ctrl)
   );

   lrnk_dp #(.REGISTRY_DEPTH(REGISTRY_DEPTH), .BEST_LIST_DEPTH(BEST_LIST_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .ctrl(ctrl), .stat(stat),
      .rsp_valid(rsp_strobe), .rsp(rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/core/lrnk_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Light registry port checker
// Checks result framing against the request handshake.
// ----------------------------------------------------------------------------
module lrnk_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_strobe,
   input wire lrnk_pkg::rsp_type_type rsp_data
);
   import lrnk_pkg::*;

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || $past(start)) else $error("beat without request");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_FULL |-> rsp_data.light_index == 5'd0)
      else $error("full beat index");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_NONE |-> rsp_data.last_result)
      else $error("none beat not last");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_result |-> !busy || $past(start && !busy))
      else $error("busy after last");

endmodule

bind light_registry_nearest_k_top lrnk_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);
`default_nettype wire
